// ===== design/clook_disk_head_movement_unit_assert.svh =====
`ifndef CLOOK_DISK_HEAD_MOVEMENT_UNIT_ASSERT_SVH
`define CLOOK_DISK_HEAD_MOVEMENT_UNIT_ASSERT_SVH
// implication checked at the same edge
`define CDHM_ASSERT_SAME(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// implication checked at the next edge
`define CDHM_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== design/cdhm_pkg.sv =====
package cdhm_pkg;
	localparam int MAX_REQUESTS = 128;
	localparam int TRACK_BITS   = 16;
	localparam int ADDR_W       = $clog2(MAX_REQUESTS);
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int MOVE_W       = 18;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_UP = 2'd1;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic store;       // input transfer: write request into store
		logic clear_scan;  // reset scan pointer and extrema
		logic scan;        // sweep the store
		logic sum;         // form total from extrema
		logic clear_count; // batch delivered
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} status_t;
endpackage

// ===== design/clook_disk_head_movement_unit.sv =====
// C-LOOK head movement: requests load one per cycle into a 128-entry store
// until the marked one; the block then stalls input, sweeps the store once
// (one entry a cycle through the single RAM read port) to find the extremes
// of the groups at or below and strictly above start_head, and forms the
// total in the SUM state; total_movement is then offered and held while
// out_stall is high. Requests past 128 are dropped.
module clook_disk_head_movement_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cdhm_pkg::TRACK_BITS-1:0] track,
	input  logic                            last_request,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cdhm_pkg::MOVE_W-1:0]     total_movement,
	input  logic                            cfg_we,
	input  logic [cdhm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdhm_pkg::CFG_DATA_W-1:0] cfg_data
);
	cdhm_pkg::cmd_t    cmd;
	cdhm_pkg::status_t sts;

	cdhm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.last_request (last_request),
		.out_stall    (out_stall),
		.sts          (sts),
		.cmd          (cmd),
		.in_stall     (in_stall),
		.out_valid    (out_valid)
	);

	cdhm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.track          (track),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.total_movement (total_movement)
	);
endmodule

// ===== design/cdhm_ram.sv =====
module cdhm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/cdhm_ctrl.sv =====
module cdhm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_request,
	input  logic             out_stall,
	input  cdhm_pkg::status_t sts,
	output cdhm_pkg::cmd_t   cmd,
	output logic             in_stall,
	output logic             out_valid
);
	cdhm_pkg::state_t state_q, state_d;
	logic in_xfer;

	assign in_stall  = (state_q != cdhm_pkg::ST_LOAD);
	assign out_valid = (state_q == cdhm_pkg::ST_OUT);
	assign in_xfer   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			cdhm_pkg::ST_LOAD: begin
				cmd.store = in_xfer;
				if (in_xfer && last_request) begin
					cmd.clear_scan = 1'b1;
					state_d = cdhm_pkg::ST_SCAN;
				end
			end
			cdhm_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = cdhm_pkg::ST_SUM;
			end
			cdhm_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = cdhm_pkg::ST_OUT;
			end
			cdhm_pkg::ST_OUT: begin
				if (!out_stall) begin
					cmd.clear_count = 1'b1;
					state_d = cdhm_pkg::ST_LOAD;
				end
			end
			default: state_d = cdhm_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdhm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== design/cdhm_dp.sv =====
module cdhm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdhm_pkg::cmd_t                      cmd,
	output cdhm_pkg::status_t                   sts,
	input  logic [cdhm_pkg::TRACK_BITS-1:0]     track,
	input  logic                                cfg_we,
	input  logic [cdhm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cdhm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [cdhm_pkg::MOVE_W-1:0]         total_movement
);
	localparam int TW = cdhm_pkg::TRACK_BITS;
	localparam int MW = cdhm_pkg::MOVE_W;

	logic [TW-1:0] head_q;
	logic          dir_up_q;
	logic [cdhm_pkg::CNT_W-1:0] count_q, rd_q;
	logic          rv_s1;
	logic [TW-1:0] rdata;
	logic          has_lo_q, has_hi_q;
	logic [TW-1:0] min_lo_q, max_lo_q, min_hi_q, max_hi_q;
	logic [MW-1:0] total_q;
	logic          wr_en, rd_en;
	logic [MW-1:0] h, mnl, mxl, mnh, mxh, sum_d;

	assign wr_en = cmd.store && (count_q < cdhm_pkg::CNT_W'(cdhm_pkg::MAX_REQUESTS));
	assign rd_en = cmd.scan && (rd_q < count_q);
	assign sts.scan_done = (rd_q == count_q) && !rv_s1;
	assign total_movement = total_q;

	cdhm_ram #(.WIDTH(TW), .DEPTH(cdhm_pkg::MAX_REQUESTS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[cdhm_pkg::ADDR_W-1:0]),
		.wdata (track),
		.raddr (rd_q[cdhm_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			dir_up_q <= 1'b1;
			count_q  <= '0;
			rd_q     <= '0;
			rv_s1    <= 1'b0;
			has_lo_q <= 1'b0;
			has_hi_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cdhm_pkg::REG_START_HEAD:   head_q   <= cfg_data[TW-1:0];
					cdhm_pkg::REG_DIRECTION_UP: dir_up_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.clear_scan) begin
				rd_q     <= '0;
				rv_s1    <= 1'b0;
				has_lo_q <= 1'b0;
				has_hi_q <= 1'b0;
			end else begin
				rv_s1 <= rd_en;
				if (rd_en) rd_q <= rd_q + 1'b1;
				if (rv_s1) begin
					if (rdata > head_q) has_hi_q <= 1'b1;
					else has_lo_q <= 1'b1;
				end
			end
		end
	end

	// extrema of the groups at or below and strictly above the head
	always_ff @(posedge clk) begin
		if (rv_s1 && !cmd.clear_scan) begin
			if (rdata > head_q) begin
				if (!has_hi_q || rdata < min_hi_q) min_hi_q <= rdata;
				if (!has_hi_q || rdata > max_hi_q) max_hi_q <= rdata;
			end else begin
				if (!has_lo_q || rdata < min_lo_q) min_lo_q <= rdata;
				if (!has_lo_q || rdata > max_lo_q) max_lo_q <= rdata;
			end
		end
		if (cmd.sum) total_q <= sum_d;
	end

	assign h   = MW'(head_q);
	assign mnl = MW'(min_lo_q);
	assign mxl = MW'(max_lo_q);
	assign mnh = MW'(min_hi_q);
	assign mxh = MW'(max_hi_q);

	// at most three span terms of 16 bits each, never overflows the 18-bit sum
	always_comb begin
		if (dir_up_q) begin
			if (has_hi_q) begin
				sum_d = (mxh - h) + (has_lo_q ? ((mxh - mnl) + (mxl - mnl)) : '0);
			end else begin
				sum_d = (h - mnl) + (mxl - mnl);
			end
		end else begin
			if (has_lo_q) begin
				sum_d = (h - mnl) + (has_hi_q ? ((mxh - mnl) + (mxh - mnh)) : '0);
			end else begin
				sum_d = (mxh - h) + (mxh - mnh);
			end
		end
	end
endmodule

// ===== design/cdhm_checker.sv =====
`include "clook_disk_head_movement_unit_assert.svh"
module cdhm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            last_request,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [cdhm_pkg::MOVE_W-1:0]     total_movement
);
	`CDHM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")
	`CDHM_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(total_movement), "result changed")
	`CDHM_ASSERT_SAME(a_busy_when_out, clk, arst_n, out_valid, in_stall, "input open with result")
	`CDHM_ASSERT_NEXT(a_no_early_out, clk, arst_n, in_valid && !in_stall && !last_request, !out_valid, "result without mark")
	`CDHM_ASSERT_NEXT(a_mark_closes, clk, arst_n, in_valid && !in_stall && last_request, in_stall, "input open after mark")
endmodule

bind clook_disk_head_movement_unit cdhm_checker u_chk (.*);
